FILE: rtl/srrq_pkg.sv
// srrq_pkg: shared types and codes for the sharded round-robin queue
// no dependencies; used by srrq_ctrl and sharded_round_robin_queue_unit
package srrq_pkg;

  // request kinds
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_CLOSE = 2'd2;

  // result status codes
  typedef enum logic [2:0] {
    ST_PUSHED     = 3'd0,
    ST_REF_CLOSED = 3'd1,
    ST_REF_FULL   = 3'd2,
    ST_POPPED     = 3'd3,
    ST_EMPTY_OPEN = 3'd4,
    ST_SHUT       = 3'd5
  } status_e;

  // registered result word, minus the popped data which comes from the bank memory
  typedef struct packed {
    logic       valid;
    status_e    status;
    logic       popped;
    logic [7:0] pending;
    logic       shut;
  } result_t;

endpackage

FILE: rtl/srrq_mem.sv
// srrq_mem: bank storage, one write port and one registered read port
// no package dependencies
module srrq_mem #(
  parameter int unsigned AW = 7
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [31:0]   wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [31:0]   rd_data_o
);

  localparam int unsigned Depth = 1 << AW;

  logic [31:0] mem_q [Depth];
  logic [31:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/srrq_ctrl.sv
// srrq_ctrl: per-bank head and fill, tickets, count, shut flag and bank scan
// depends on srrq_pkg; drives the ports of srrq_mem
module srrq_ctrl #(
  parameter int unsigned BANKS      = 8,
  parameter int unsigned BANK_DEPTH = 16,
  parameter int unsigned BW         = 3,
  parameter int unsigned DW         = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          req_type_i,
  output logic                wr_en_o,
  output logic [BW+DW-1:0]    wr_addr_o,
  output logic                rd_en_o,
  output logic [BW+DW-1:0]    rd_addr_o,
  output srrq_pkg::result_t   result_o
);

  localparam int unsigned FW = $clog2(BANK_DEPTH + 1);
  localparam int unsigned TW = $clog2(BANKS * BANK_DEPTH + 1);

  logic [DW-1:0] head_q [BANKS];
  logic [DW-1:0] head_d [BANKS];
  logic [FW-1:0] fill_q [BANKS];
  logic [FW-1:0] fill_d [BANKS];
  logic [BW-1:0] push_tkt_q, push_tkt_d;
  logic [BW-1:0] pop_tkt_q, pop_tkt_d;
  logic [TW-1:0] total_q, total_d;
  logic          shut_q, shut_d;
  srrq_pkg::result_t res_q, res_d;

  logic [BANKS-1:0] rot_ne;
  logic [BW-1:0]    first;
  logic             found;
  logic [BW:0]      pop_bank_w;
  logic [BW-1:0]    pop_bank;
  logic [FW:0]      slot_sum;
  logic [DW:0]      head_inc;
  logic [TW+7:0]    total_ext;

  function automatic logic [BW-1:0] next_bank(input logic [BW-1:0] b);
    logic [BW:0] n;
    n = {1'b0, b} + (BW+1)'(1);
    if (n >= (BW+1)'(BANKS)) begin
      n = '0;
    end
    return n[BW-1:0];
  endfunction

  // non-empty flags rotated so that bit 0 is the pop ticket's bank
  always_comb begin
    logic [BW:0] idx;
    for (int i = 0; i < BANKS; i++) begin
      idx = {1'b0, pop_tkt_q} + (BW+1)'(i);
      if (idx >= (BW+1)'(BANKS)) begin
        idx = idx - (BW+1)'(BANKS);
      end
      rot_ne[i] = (fill_q[idx[BW-1:0]] != '0);
    end
  end

  // first non-empty bank from the ticket on
  always_comb begin
    first = '0;
    found = 1'b0;
    for (int i = BANKS - 1; i >= 0; i--) begin
      if (rot_ne[i]) begin
        first = BW'(i);
        found = 1'b1;
      end
    end
    pop_bank_w = {1'b0, pop_tkt_q} + {1'b0, first};
    if (pop_bank_w >= (BW+1)'(BANKS)) begin
      pop_bank_w = pop_bank_w - (BW+1)'(BANKS);
    end
    pop_bank = pop_bank_w[BW-1:0];
  end

  // tail slot of the push bank and next head of the pop bank
  always_comb begin
    slot_sum = (FW+1)'(head_q[push_tkt_q]) + (FW+1)'(fill_q[push_tkt_q]);
    if (slot_sum >= (FW+1)'(BANK_DEPTH)) begin
      slot_sum = slot_sum - (FW+1)'(BANK_DEPTH);
    end
    head_inc = {1'b0, head_q[pop_bank]} + (DW+1)'(1);
    if (head_inc >= (DW+1)'(BANK_DEPTH)) begin
      head_inc = '0;
    end
  end

  // request decode and state update
  always_comb begin
    head_d     = head_q;
    fill_d     = fill_q;
    push_tkt_d = push_tkt_q;
    pop_tkt_d  = pop_tkt_q;
    total_d    = total_q;
    shut_d     = shut_q;
    wr_en_o    = 1'b0;
    rd_en_o    = 1'b0;
    wr_addr_o  = {push_tkt_q, slot_sum[DW-1:0]};
    rd_addr_o  = {pop_bank, head_q[pop_bank]};
    res_d        = res_q;
    res_d.valid  = accept_i;
    if (accept_i) begin
      res_d.popped = 1'b0;
      res_d.status = shut_q ? srrq_pkg::ST_SHUT : srrq_pkg::ST_EMPTY_OPEN;
      case (req_type_i)
        srrq_pkg::REQ_PUSH: begin
          if (shut_q) begin
            res_d.status = srrq_pkg::ST_REF_CLOSED;
          end else if (fill_q[push_tkt_q] == FW'(BANK_DEPTH)) begin
            res_d.status = srrq_pkg::ST_REF_FULL;
          end else begin
            wr_en_o              = 1'b1;
            fill_d[push_tkt_q]   = fill_q[push_tkt_q] + FW'(1);
            total_d              = total_q + TW'(1);
            push_tkt_d           = next_bank(push_tkt_q);
            res_d.status         = srrq_pkg::ST_PUSHED;
          end
        end
        srrq_pkg::REQ_POP: begin
          pop_tkt_d = next_bank(pop_tkt_q);
          if (found) begin
            rd_en_o          = 1'b1;
            head_d[pop_bank] = head_inc[DW-1:0];
            fill_d[pop_bank] = fill_q[pop_bank] - FW'(1);
            total_d          = total_q - TW'(1);
            res_d.status     = srrq_pkg::ST_POPPED;
            res_d.popped     = 1'b1;
          end
        end
        srrq_pkg::REQ_CLOSE: begin
          shut_d       = 1'b1;
          res_d.status = srrq_pkg::ST_SHUT;
        end
        default: begin
          res_d.status = shut_q ? srrq_pkg::ST_SHUT : srrq_pkg::ST_EMPTY_OPEN;
        end
      endcase
      res_d.shut    = shut_d;
      res_d.pending = total_ext[7:0];
    end
  end

  assign total_ext = {8'b0, total_d};

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BANKS; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
      push_tkt_q <= '0;
      pop_tkt_q  <= '0;
      total_q    <= '0;
      shut_q     <= 1'b0;
      res_q      <= '0;
    end else begin
      head_q     <= head_d;
      fill_q     <= fill_d;
      push_tkt_q <= push_tkt_d;
      pop_tkt_q  <= pop_tkt_d;
      total_q    <= total_d;
      shut_q     <= shut_d;
      res_q      <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

FILE: rtl/sharded_round_robin_queue_unit.sv
// sharded_round_robin_queue_unit: top level, control plus bank memory
// depends on srrq_pkg, srrq_ctrl and srrq_mem
//
// Usage:
//   A request word (req_type_i, push_value_i) is taken at a rising edge where
//   start is high and busy is low. busy stays low: the bank state is
//   updated at the accept edge, so a new request may follow every cycle.
//   Each request gives exactly one result word in the next cycle, shown for one
//   cycle with done_o high: status_o, pop_value_o, pending_count_o, is_shut_o.
//   Throughput is 1 request per cycle. The pop value comes
//   from the bank memory's registered read port, read at the accept edge; a
//   push writes the tail slot of its bank at the accept edge.
//   The bank scan for a pop is a rotating priority select over the per-bank
//   fill flags, starting at the pop ticket.
//   Reset clears heads, fills, tickets, the count and the shut flag at once;
//   the bank memory itself is not cleared, since only written slots are read.
//   The receiver cannot stall: results must be taken in the cycle shown.
module sharded_round_robin_queue_unit #(
  parameter int unsigned BANKS      = 8,
  parameter int unsigned BANK_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] push_value_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic signed [31:0] pop_value_o,
  output logic [7:0]         pending_count_o,
  output logic               is_shut_o
);

  localparam int unsigned BW = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int unsigned DW = $clog2(BANK_DEPTH);
  localparam int unsigned AW = BW + DW;

  logic              accept;
  logic              wr_en;
  logic              rd_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [31:0]       rd_data;
  srrq_pkg::result_t result;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // bank bookkeeping and scan
  srrq_ctrl #(
    .BANKS      (BANKS),
    .BANK_DEPTH (BANK_DEPTH),
    .BW         (BW),
    .DW         (DW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_type_i (req_type_i),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .result_o   (result)
  );

  // bank storage
  srrq_mem #(
    .AW (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (push_value_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // result word
  assign done_o          = result.valid;
  assign status_o        = result.status;
  assign pop_value_o     = result.popped ? rd_data : 32'sd0;
  assign pending_count_o = result.pending;
  assign is_shut_o       = result.shut;

`ifndef SYNTH
  a_accept_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o) else $error("accepted request gave no result");

  a_no_spurious_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o) else $error("result without a request");

  a_value_only_on_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != srrq_pkg::ST_POPPED) |-> pop_value_o == 32'sd0)
    else $error("nonzero pop value without a pop");

  a_shut_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_shut_o |=> is_shut_o) else $error("shut flag cleared");
`endif

endmodule

FILE: tb/srrq_response_checker.sv
`timescale 1ns / 1ps
// srrq_response_checker: predicts and checks every result word of the sharded queue
// depends on srrq_pkg; instantiated by testbench beside the unit under test
module srrq_response_checker #(
  parameter int unsigned BANKS      = 8,
  parameter int unsigned BANK_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] push_value_i,
  input  logic               done_i,
  input  logic [2:0]         status_i,
  input  logic signed [31:0] pop_value_i,
  input  logic [7:0]         pending_count_i,
  input  logic               is_shut_i,
  output int                 fail_count_o,
  output int                 pending_words_o,
  output int                 words_checked_o,
  output int                 pops_checked_o,
  output int                 fulls_checked_o,
  output int                 closed_checked_o
);

  localparam int unsigned RING_DEPTH = 64;

  typedef struct {
    srrq_pkg::status_e  status;
    logic signed [31:0] value;
    logic [7:0]         pending;
    logic               shut;
  } response_t;

  // shadow copy of the bank state
  logic signed [31:0] bank_words [BANKS][BANK_DEPTH];
  int unsigned        bank_head  [BANKS];
  int unsigned        bank_fill  [BANKS];
  int unsigned        push_bank;
  int unsigned        pop_bank;
  int unsigned        held_total;
  logic               shut_seen;

  // expected result words in order of acceptance
  response_t   expect_ring [RING_DEPTH];
  int unsigned ring_rd;
  int unsigned ring_wr;
  int unsigned ring_count;
  response_t   oldest;
  int          fails;
  int          checked;
  int          pops;
  int          fulls;
  int          closed_refusals;

  function automatic int unsigned next_bank(input int unsigned b);
    return (b + 1 >= BANKS) ? 0 : b + 1;
  endfunction

  // one request applied to the shadow state, giving the result word it causes
  function automatic response_t predict_response(input logic [1:0] kind,
                                                 input logic signed [31:0] value);
    response_t   r;
    int unsigned b;
    int unsigned slot;
    bit          found;
    r.value = '0;
    r.status = shut_seen ? srrq_pkg::ST_SHUT : srrq_pkg::ST_EMPTY_OPEN;
    case (kind)
      srrq_pkg::REQ_PUSH: begin
        b = push_bank;
        if (shut_seen) begin
          r.status = srrq_pkg::ST_REF_CLOSED;
        end else if (bank_fill[b] >= BANK_DEPTH) begin
          r.status = srrq_pkg::ST_REF_FULL;
        end else begin
          slot = (bank_head[b] + bank_fill[b]) % BANK_DEPTH;
          bank_words[b][slot] = value;
          bank_fill[b]++;
          held_total++;
          push_bank = next_bank(b);
          r.status = srrq_pkg::ST_PUSHED;
        end
      end
      srrq_pkg::REQ_POP: begin
        b = pop_bank;
        pop_bank = next_bank(b);
        found = 1'b0;
        // rotating scan for the first bank holding a word
        for (int i = 0; i < BANKS; i++) begin
          if (!found) begin
            if (bank_fill[b] != 0) begin
              r.value = bank_words[b][bank_head[b]];
              bank_head[b] = (bank_head[b] + 1) % BANK_DEPTH;
              bank_fill[b]--;
              if (held_total != 0) held_total--;
              found = 1'b1;
              r.status = srrq_pkg::ST_POPPED;
            end else begin
              b = next_bank(b);
            end
          end
        end
      end
      srrq_pkg::REQ_CLOSE: begin
        shut_seen = 1'b1;
        r.status = srrq_pkg::ST_SHUT;
      end
      default: ;
    endcase
    r.pending = held_total[7:0];
    r.shut = shut_seen;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BANKS; b++) begin
        bank_head[b] = 0;
        bank_fill[b] = 0;
      end
      push_bank = 0;
      pop_bank = 0;
      held_total = 0;
      shut_seen = 1'b0;
      ring_rd = 0;
      ring_wr = 0;
      ring_count = 0;
      fails = 0;
      checked = 0;
      pops = 0;
      fulls = 0;
      closed_refusals = 0;
    end else begin
      // compare the word shown this cycle with the oldest expectation
      if (done_i) begin
        if (ring_count == 0) begin
          fails++;
          $display("%0t: unexpected result word: status %0d value %0d pending %0d shut %0d",
                   $time, status_i, pop_value_i, pending_count_i, is_shut_i);
        end else begin
          oldest = expect_ring[ring_rd];
          ring_rd = (ring_rd + 1) % RING_DEPTH;
          ring_count--;
          checked++;
          if (status_i !== oldest.status) begin
            fails++;
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, oldest.status, status_i);
          end
          if (pop_value_i !== oldest.value) begin
            fails++;
            $display("%0t: pop value mismatch: expected %0d actual %0d",
                     $time, oldest.value, pop_value_i);
          end
          if (pending_count_i !== oldest.pending) begin
            fails++;
            $display("%0t: pending count mismatch: expected %0d actual %0d",
                     $time, oldest.pending, pending_count_i);
          end
          if (is_shut_i !== oldest.shut) begin
            fails++;
            $display("%0t: shut flag mismatch: expected %0d actual %0d",
                     $time, oldest.shut, is_shut_i);
          end
          case (oldest.status)
            srrq_pkg::ST_POPPED:     pops++;
            srrq_pkg::ST_REF_FULL:   fulls++;
            srrq_pkg::ST_REF_CLOSED: closed_refusals++;
            default: ;
          endcase
        end
      end
      // accepted request word
      if (start && !busy) begin
        if (ring_count >= RING_DEPTH) begin
          fails++;
          $display("%0t: too many result words outstanding: expected at most %0d actual %0d",
                   $time, RING_DEPTH, ring_count + 1);
        end else begin
          expect_ring[ring_wr] = predict_response(req_type_i, push_value_i);
          ring_wr = (ring_wr + 1) % RING_DEPTH;
          ring_count++;
        end
      end
    end
    fail_count_o     <= fails;
    pending_words_o  <= ring_count;
    words_checked_o  <= checked;
    pops_checked_o   <= pops;
    fulls_checked_o  <= fulls;
    closed_checked_o <= closed_refusals;
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: request stimulus and verdict for sharded_round_robin_queue_unit
// depends on srrq_pkg, the unit and srrq_response_checker
module testbench;

  localparam int unsigned BANKS       = 8;
  localparam int unsigned BANK_DEPTH  = 16;
  localparam logic [1:0]  REQ_UNKNOWN = 2'd3;
  localparam int          STALL_LIMIT = 2000;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               start        = 1'b0;
  logic [1:0]         req_type_i   = srrq_pkg::REQ_PUSH;
  logic signed [31:0] push_value_i = '0;
  logic               busy;
  logic               done_o;
  logic [2:0]         status_o;
  logic signed [31:0] pop_value_o;
  logic [7:0]         pending_count_o;
  logic               is_shut_o;

  int fail_count;
  int pending_words;
  int words_checked;
  int pops_checked;
  int fulls_checked;
  int closed_checked;
  int idle_cycles = 0;
  int words_sent  = 0;
  bit burst_mode  = 1'b0;

  always #1 clk_i = ~clk_i;

  sharded_round_robin_queue_unit #(
    .BANKS      (BANKS),
    .BANK_DEPTH (BANK_DEPTH)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .push_value_i    (push_value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .pop_value_o     (pop_value_o),
    .pending_count_o (pending_count_o),
    .is_shut_o       (is_shut_o)
  );

  srrq_response_checker #(
    .BANKS      (BANKS),
    .BANK_DEPTH (BANK_DEPTH)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .push_value_i     (push_value_i),
    .done_i           (done_o),
    .status_i         (status_o),
    .pop_value_i      (pop_value_o),
    .pending_count_i  (pending_count_o),
    .is_shut_i        (is_shut_o),
    .fail_count_o     (fail_count),
    .pending_words_o  (pending_words),
    .words_checked_o  (words_checked),
    .pops_checked_o   (pops_checked),
    .fulls_checked_o  (fulls_checked),
    .closed_checked_o (closed_checked)
  );

  // watchdog on cycles without an accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no word accepted for %0d cycles", $time, STALL_LIMIT);
        $display("** sharded_round_robin_queue_unit: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // present one request word and hold it until accepted; start stays high
  task automatic send_word(input logic [1:0] kind, input logic signed [31:0] value);
    start        <= 1'b1;
    req_type_i   <= kind;
    push_value_i <= value;
    do @(posedge clk_i); while (busy);
    words_sent++;
  endtask

  // random gap after a word: mostly none or short, sometimes long
  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // hold off until every result word has come back
  task automatic wait_all_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
  endtask

  function automatic logic signed [31:0] random_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'sh8000_0000;
    if (r == 1) return 32'sh7fff_ffff;
    if (r == 2) return $urandom_range(0, 15);
    return $urandom;
  endfunction

  // a stretch of random requests with the given mix in percent; the rest are unknown kinds
  task automatic run_mix(input int count, input int push_pct, input int pop_pct,
                         input int close_pct);
    int         r;
    logic [1:0] kind;
    burst_mode = ($urandom_range(0, 3) == 0);
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < push_pct) kind = srrq_pkg::REQ_PUSH;
      else if (r < push_pct + pop_pct) kind = srrq_pkg::REQ_POP;
      else if (r < push_pct + pop_pct + close_pct) kind = srrq_pkg::REQ_CLOSE;
      else kind = REQ_UNKNOWN;
      send_word(kind, random_value());
      sender_gap();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pop, unknown kind, extreme values, scan across banks
    send_word(srrq_pkg::REQ_POP, 32'sd0);
    send_word(REQ_UNKNOWN, 32'sh7fff_ffff);
    send_word(srrq_pkg::REQ_PUSH, 32'sh8000_0000);
    send_word(srrq_pkg::REQ_PUSH, 32'sh7fff_ffff);
    send_word(srrq_pkg::REQ_PUSH, 32'sd0);
    send_word(srrq_pkg::REQ_PUSH, -32'sd1);
    send_word(srrq_pkg::REQ_PUSH, 32'sh5555_5555);
    sender_gap();
    send_word(srrq_pkg::REQ_PUSH, 32'shaaaa_aaaa);
    send_word(srrq_pkg::REQ_PUSH, 32'sd1);
    repeat (8) begin
      send_word(srrq_pkg::REQ_POP, 32'shffff_ffff);
    end
    send_word(REQ_UNKNOWN, 32'sd0);
    send_word(srrq_pkg::REQ_PUSH, 32'sh1234_5678);
    send_word(srrq_pkg::REQ_PUSH, -32'sh1234_5678);
    wait_all_results();

    // fill until banks refuse, then drain until pops come back empty
    repeat (2) begin
      run_mix(170, 88, 8, 0);
      run_mix(160, 6, 92, 0);
    end

    // refill part way, let everything settle, then close and drain
    run_mix(60, 80, 15, 0);
    wait_all_results();
    send_word(srrq_pkg::REQ_CLOSE, $urandom);
    run_mix(140, 30, 50, 10);

    // end of stimulus: wait for every result word plus the unit's latency
    wait_all_results();
    repeat (4) @(posedge clk_i);

    $display("sent %0d request words, checked %0d result words", words_sent, words_checked);
    $display("%0d pops with data, %0d full refusals, %0d refusals after close",
             pops_checked, fulls_checked, closed_checked);
    if (fail_count == 0) begin
      $display("** sharded_round_robin_queue_unit: PASSED **");
    end else begin
      $display("** sharded_round_robin_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule
